FILE: sv/ping_pong_rx_byte_buffer_macros.svh
// Assertion macros for the ping-pong receive byte buffer.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef PING_PONG_RX_BYTE_BUFFER_MACROS_SVH
`define PING_PONG_RX_BYTE_BUFFER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define PPRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define PPRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPRB_ASSERT_IMP(lbl, ante, cons, msg)
`define PPRB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/pprb_pkg.sv
// Shared types and constants for the ping-pong receive byte buffer.
// No dependencies.
package pprb_pkg;

  localparam int PPRB_BANK_DEPTH = 16;

  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } pprb_state_t;

  typedef struct packed {
    logic rx_write;
    logic swap;
    logic rd_issue;
  } pprb_cmd_t;

  typedef struct packed {
    logic bank_full;
    logic bank_nonempty;
    logic deliver_en;
    logic rd_at_last;
  } pprb_status_t;

endpackage

FILE: sv/pprb_ctrl.sv
// Controller for the ping-pong receive byte buffer: decodes items and sequences drains.
// Depends on pprb_pkg.
module pprb_ctrl
  import pprb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         in_mode,
  input  pprb_status_t status,
  output pprb_cmd_t    cmd,
  output logic         busy
);

  pprb_state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.rx_write = 1'b0;
    cmd.swap     = 1'b0;
    cmd.rd_issue = 1'b0;
    busy         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_RX) begin
            // drop the word when the active bank is full
            cmd.rx_write = !status.bank_full;
          end else if (status.bank_nonempty) begin
            cmd.swap = 1'b1;
            if (status.deliver_en) begin
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        busy         = 1'b1;
        cmd.rd_issue = 1'b1;
        if (status.rd_at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/pprb_datapath.sv
// Datapath for the ping-pong receive byte buffer: bank counts, byte store, output word.
// Depends on pprb_pkg.
module pprb_datapath
  import pprb_pkg::*;
#(
  parameter int BANK_DEPTH = PPRB_BANK_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic [7:0]   in_byte_in,
  input  pprb_cmd_t    cmd,
  output pprb_status_t status,
  output logic         out_valid,
  output logic [7:0]   out_byte_out,
  output logic         out_last_of_run
);

  localparam int STORE_DEPTH = 2 * BANK_DEPTH;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(BANK_DEPTH);

  logic [7:0]    mem_r [STORE_DEPTH];
  logic [7:0]    rd_data_r;
  logic          deliver_en_r;
  logic          active_r;
  logic [CW-1:0] cnt0_r, cnt1_r;
  logic          drain_bank_r;
  logic [CW-1:0] drain_n_r;
  logic [CW-1:0] ptr_r;
  logic          out_valid_r, out_last_r;

  logic [CW-1:0] cnt_act;
  logic [AW-1:0] wr_addr, rd_addr;

  assign cnt_act = active_r ? cnt1_r : cnt0_r;
  assign wr_addr = AW'(cnt_act) + (active_r ? AW'(BANK_DEPTH) : AW'(0));
  assign rd_addr = AW'(ptr_r) + (drain_bank_r ? AW'(BANK_DEPTH) : AW'(0));

  assign status.bank_full     = (cnt_act == CW'(BANK_DEPTH - 1));
  assign status.bank_nonempty = (cnt_act != CW'(0));
  assign status.deliver_en    = deliver_en_r;
  assign status.rd_at_last    = (ptr_r == CW'(drain_n_r - CW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deliver_en_r <= 1'b0;
      active_r     <= 1'b0;
      cnt0_r       <= '0;
      cnt1_r       <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        deliver_en_r <= cfg_wdata;
      end
      if (cmd.rx_write) begin
        if (active_r) begin
          cnt1_r <= cnt1_r + CW'(1);
        end else begin
          cnt0_r <= cnt0_r + CW'(1);
        end
      end
      if (cmd.swap) begin
        // clear the drained bank and hand filling to the other one
        if (active_r) begin
          cnt1_r <= '0;
        end else begin
          cnt0_r <= '0;
        end
        active_r <= !active_r;
      end
      out_valid_r <= cmd.rd_issue;
      out_last_r  <= cmd.rd_issue && status.rd_at_last;
    end
  end

  // drain bookkeeping; only meaningful while a drain runs
  always_ff @(posedge clk) begin
    if (cmd.swap) begin
      drain_bank_r <= active_r;
      drain_n_r    <= cnt_act;
      ptr_r        <= '0;
    end else if (cmd.rd_issue) begin
      ptr_r <= ptr_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_write) begin
      mem_r[wr_addr] <= in_byte_in;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = rd_data_r;
  assign out_last_of_run = out_last_r;

endmodule

FILE: sv/ping_pong_rx_byte_buffer.sv
// Top level of the ping-pong receive byte buffer: controller plus datapath.
// Depends on pprb_pkg, pprb_ctrl, pprb_datapath and the assertion macro header.
//
// A receive word (in_mode 0) yields nothing. A tick (in_mode 1) on a bank holding
// n bytes with delivery on keeps busy high while the bank is drained, one read
// of the byte store's single read port per cycle; each byte appears on out_byte_out
// with out_valid in the cycle after its read, so the last (out_last_of_run) arrives
// in the same cycle that busy falls. Results cannot be stalled: sample them whenever
// out_valid is high. A tick on an empty bank, or with delivery off, starts no drain.
`include "ping_pong_rx_byte_buffer_macros.svh"
module ping_pong_rx_byte_buffer
  import pprb_pkg::*;
#(
  parameter int BANK_DEPTH = PPRB_BANK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_mode,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  output logic [7:0] out_byte_out,
  output logic       out_last_of_run,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  pprb_cmd_t    cmd;
  pprb_status_t status;

  pprb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  pprb_datapath #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_byte_in      (in_byte_in),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_byte_out    (out_byte_out),
    .out_last_of_run (out_last_of_run)
  );

  `PPRB_ASSERT_NXT(a_read_gives_word, cmd.rd_issue, out_valid, "read issued but no word out")
  `PPRB_ASSERT_NXT(a_no_stray_word, !cmd.rd_issue, !out_valid, "word out without a read")
  `PPRB_ASSERT_IMP(a_swap_needs_data, cmd.swap, status.bank_nonempty, "swap on empty bank")
  `PPRB_ASSERT_NXT(a_last_ends_run, out_valid && out_last_of_run, !out_valid, "word after last")

endmodule

FILE: dv/tb_ping_pong_rx_byte_buffer.sv
`timescale 1ns / 1ps
// Self-checking testbench for ping_pong_rx_byte_buffer: directed and random words with a predictor.
// Depends on pprb_pkg and the ping_pong_rx_byte_buffer RTL.
module tb_ping_pong_rx_byte_buffer;
  import pprb_pkg::*;

  localparam int DEPTH = PPRB_BANK_DEPTH;
  localparam int HOLD_CYCLES = DEPTH + 4;

  typedef struct {
    logic       mode;
    logic [7:0] data;
  } rx_word_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } drained_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_mode = MODE_RX;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic [7:0] out_byte_out;
  logic       out_last_of_run;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;

  ping_pong_rx_byte_buffer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_byte_out   (out_byte_out),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // words waiting for the driver, and drained bytes the block still owes
  rx_word_t      word_q[$];
  drained_byte_t drain_q[$];
  rx_word_t      held_word;
  int            idle_pct = 0;

  // predictor state
  logic       deliver_on = 1'b0;
  logic       fill_bank = 1'b0;
  int         fill_cnt[2] = '{0, 0};
  logic [7:0] bank_mem[2][DEPTH];

  int err_count = 0;
  int words_taken = 0;
  int swaps_seen = 0;
  int drops_seen = 0;
  int bytes_checked = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d words in queue, %0d bytes still owed", word_q.size(), drain_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void predict_word(input rx_word_t w);
    logic b;
    int   n;
    b = fill_bank;
    if (w.mode == MODE_RX) begin
      if (fill_cnt[b] < DEPTH - 1) begin
        bank_mem[b][fill_cnt[b]] = w.data;
        fill_cnt[b]++;
      end else begin
        drops_seen++;
      end
    end else begin
      n = fill_cnt[b];
      // empty tick: no swap, nothing owed
      if (n != 0) begin
        fill_bank = ~b;
        fill_cnt[b] = 0;
        swaps_seen++;
        if (deliver_on) begin
          for (int i = 0; i < n; i++) begin
            drain_q.push_back('{data: bank_mem[b][i], last: (i == n - 1)});
          end
        end
      end
    end
  endfunction

  // driver: hold the word until accepted, then present the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_word(held_word);
        words_taken++;
      end
      if (!start || !busy) begin
        if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          held_word = word_q.pop_front();
          start <= 1'b1;
          in_mode <= held_word.mode;
          in_byte_in <= held_word.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, take each one as it comes
  always @(posedge clk) begin
    drained_byte_t want;
    if (rst_n && out_valid) begin
      if (drain_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte_out,
                                  out_last_of_run));
      end else begin
        want = drain_q.pop_front();
        bytes_checked++;
        if (out_byte_out !== want.data)
          report_mismatch($sformatf("byte_out %02h, want %02h", out_byte_out, want.data));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0b, want %0b", out_last_of_run, want.last));
      end
    end
  end

  task automatic push_word(input logic mode, input logic [7:0] data);
    word_q.push_back('{mode: mode, data: data});
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || start || drain_q.size() != 0 || busy !== 1'b0)
      @(posedge clk);
    // a tick with delivery off owes nothing and starts no drain; then idle for HOLD_CYCLES
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_deliver(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    deliver_on = v;
  endtask

  // mostly fill runs closed by a tick; some overfill the bank, some noise
  task automatic push_random(input int count);
    int added;
    int len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 8) begin
        push_word(1'($urandom_range(1)), 8'($urandom_range(255)));
        added++;
      end else begin
        len = ($urandom_range(99) < 12) ? $urandom_range(DEPTH - 1, DEPTH + 4)
                                        : $urandom_range(1, DEPTH - 2);
        repeat (len) push_word(MODE_RX, 8'($urandom_range(255)));
        push_word(MODE_TICK, 8'($urandom_range(255)));
        added += len + 1;
        if ($urandom_range(99) < 10) begin
          push_word(MODE_TICK, 8'($urandom_range(255)));
          added++;
        end
      end
    end
  endtask

  initial begin
    logic phase_deliver[6];
    int   phase_idle[6];
    phase_deliver = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_idle = '{0, 55, 55, 26, 0, 26};
    wait (rst_n === 1'b1);
    @(posedge clk);

    // delivery off out of reset: the tick swaps but emits nothing
    push_word(MODE_RX, 8'hA5);
    push_word(MODE_TICK, 8'h00);
    wait_drained();

    write_deliver(1'b1);
    push_word(MODE_RX, 8'h00);
    push_word(MODE_RX, 8'hFF);
    push_word(MODE_TICK, 8'hFF);
    push_word(MODE_TICK, 8'h5A);
    // overfill: the sixteenth byte is dropped
    for (int i = 0; i < DEPTH; i++) push_word(MODE_RX, 8'(i * 17));
    push_word(MODE_TICK, 8'h00);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_deliver(phase_deliver[p]);
      idle_pct = phase_idle[p];
      push_random(85);
      wait_drained();
    end

    if (drain_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", drain_q.size()));
    $display("Covered %0d words: %0d bank swaps, %0d bytes dropped on a full bank,",
             words_taken, swaps_seen, drops_seen);
    $display("%0d drained bytes checked, delivery on and off, sender gaps 0/26/55 percent",
             bytes_checked);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/pprb_pkg.sv
sv/pprb_ctrl.sv
sv/pprb_datapath.sv
sv/ping_pong_rx_byte_buffer.sv
dv/tb_ping_pong_rx_byte_buffer.sv
